### sv/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;

    localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 8'd60;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_QUEUED_NORMAL   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED_PRIORITY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NORMAL_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRIORITY_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_REJECTED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED         = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BOTH_EMPTY      = 3'd6;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

endpackage

### sv/tcpq_fifo.sv
// ----------------------------------------------------------------------------
// tcpq_fifo
// One circular queue: storage memory, head and tail pointers, fill count.
// ----------------------------------------------------------------------------
module tcpq_fifo
    import tcpq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             pop,
    input  logic [VALUE_W-1:0]               wdata,
    output logic [VALUE_W-1:0]               rdata,
    output logic [$clog2(DEPTH+1)-1:0]       fill,
    output logic                             full,
    output logic                             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [VALUE_W-1:0] mem_reg [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_reg;
    logic [PTR_W-1:0]   tail_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    // The head entry is read into a register on every edge, so it is ready in
    // the cycle after the pointers settle.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= wdata;
        end
        rdata_reg <= mem_reg[head_reg];
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH-1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH-1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    assign rdata = rdata_reg;
    assign fill  = fill_reg;
    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);

endmodule

### sv/tcpq_datapath.sv
// ----------------------------------------------------------------------------
// tcpq_datapath
// Item and threshold registers, the two queues, the routing decision and
// the result register.
// ----------------------------------------------------------------------------
module tcpq_datapath
    import tcpq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           ctrl_cmd,
    input  logic                cfg_we,
    input  logic [VALUE_W-1:0]  cfg_data,
    input  logic                command,
    input  logic [VALUE_W-1:0]  item_value,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0]  removed_value,
    output logic                removed_from_priority,
    output logic [COUNT_W-1:0]  normal_count,
    output logic [COUNT_W-1:0]  priority_count
);

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [VALUE_W-1:0]  threshold_reg;
    logic                cmd_reg;
    logic [VALUE_W-1:0]  value_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [VALUE_W-1:0]  removed_reg;
    logic [VALUE_W-1:0]  removed_next;
    logic                from_prio_reg;
    logic                from_prio_next;
    logic [COUNT_W-1:0]  ncount_reg;
    logic [COUNT_W-1:0]  ncount_next;
    logic [COUNT_W-1:0]  pcount_reg;
    logic [COUNT_W-1:0]  pcount_next;

    logic                npush;
    logic                npop;
    logic                ppush;
    logic                ppop;
    logic                nfull;
    logic                nempty;
    logic                pfull;
    logic                pempty;
    logic [VALUE_W-1:0]  nrdata;
    logic [VALUE_W-1:0]  prdata;
    logic [CNT_W-1:0]    nfill;
    logic [CNT_W-1:0]    pfill;
    logic                do_npush;
    logic                do_npop;
    logic                do_ppush;
    logic                do_ppop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.capture)
        begin
            cmd_reg   <= command;
            value_reg <= item_value;
        end
        if (ctrl_cmd.commit)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            from_prio_reg <= from_prio_next;
            ncount_reg    <= ncount_next;
            pcount_reg    <= pcount_next;
        end
    end

    always_comb
    begin
        do_npush       = 1'b0;
        do_npop        = 1'b0;
        do_ppush       = 1'b0;
        do_ppop        = 1'b0;
        removed_next   = '0;
        from_prio_next = 1'b0;
        status_next    = ST_BOTH_EMPTY;
        if (cmd_reg == CMD_INSERT)
        begin
            priority if (value_reg == '0)
            begin
                status_next = ST_ZERO_REJECTED;
            end
            else if (value_reg >= threshold_reg)
            begin
                do_ppush    = !pfull;
                status_next = pfull ? ST_PRIORITY_FULL : ST_QUEUED_PRIORITY;
            end
            else
            begin
                do_npush    = !nfull;
                status_next = nfull ? ST_NORMAL_FULL : ST_QUEUED_NORMAL;
            end
        end
        else
        begin
            priority if (!pempty)
            begin
                do_ppop        = 1'b1;
                removed_next   = prdata;
                from_prio_next = 1'b1;
                status_next    = ST_REMOVED;
            end
            else if (!nempty)
            begin
                do_npop      = 1'b1;
                removed_next = nrdata;
                status_next  = ST_REMOVED;
            end
            else
            begin
                status_next = ST_BOTH_EMPTY;
            end
        end
        ncount_next = COUNT_W'(nfill + CNT_W'(do_npush) - CNT_W'(do_npop));
        pcount_next = COUNT_W'(pfill + CNT_W'(do_ppush) - CNT_W'(do_ppop));
    end

    assign npush = ctrl_cmd.commit && do_npush;
    assign npop  = ctrl_cmd.commit && do_npop;
    assign ppush = ctrl_cmd.commit && do_ppush;
    assign ppop  = ctrl_cmd.commit && do_ppop;

    tcpq_fifo #(.DEPTH(DEPTH)) u_normal (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (npush),
        .pop   (npop),
        .wdata (value_reg),
        .rdata (nrdata),
        .fill  (nfill),
        .full  (nfull),
        .empty (nempty)
    );

    tcpq_fifo #(.DEPTH(DEPTH)) u_priority (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ppush),
        .pop   (ppop),
        .wdata (value_reg),
        .rdata (prdata),
        .fill  (pfill),
        .full  (pfull),
        .empty (pempty)
    );

    assign status                = status_reg;
    assign removed_value         = removed_reg;
    assign removed_from_priority = from_prio_reg;
    assign normal_count          = ncount_reg;
    assign priority_count        = pcount_reg;

endmodule

### sv/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Controller: input handshake, execute step and result valid flag.
// ----------------------------------------------------------------------------
module tcpq_ctrl
    import tcpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output ctrl_cmd_t ctrl_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic load_ok;

    // The result register may be refilled when it is empty or its current item leaves.
    assign load_ok          = !out_valid_reg || !out_stall;
    assign in_stall         = (state_reg != S_IDLE);
    assign ctrl_cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign ctrl_cmd.commit  = (state_reg == S_EXEC) && load_ok;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (load_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        priority if (ctrl_cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/two_class_priority_fifo.sv
// ----------------------------------------------------------------------------
// two_class_priority_fifo
// Two-class strict priority queue: normal and priority FIFOs in one block.
// ----------------------------------------------------------------------------
// Usage:
// An item on the input channel (in_valid, in_stall) is an insert of
// item_value (command 0) or a remove (command 1). Each item gives one result
// item on the output channel (out_valid, out_stall) with a status code, the
// removed value and both queue occupancies after the operation.
// An accepted item is captured, then committed in the execute step, which
// waits for the registered read of each queue's head entry and for a free
// output register; no new item is taken before the commit.
// The result sits in an output register, so the next item is taken while a
// result still waits; if the receiver stalls, that item waits in the execute step.
// priority_threshold is written through cfg_valid/cfg_ready/cfg_data; the
// user must write it only while the block is idle, which the block does not
// enforce. cfg_ready is always high.
// Reset empties both queues, sets the threshold to 60 and drops any result.
// ----------------------------------------------------------------------------
module two_class_priority_fifo
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [VALUE_W-1:0]  item_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [VALUE_W-1:0]  cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0]  removed_value,
    output logic                removed_from_priority,
    output logic [COUNT_W-1:0]  normal_count,
    output logic [COUNT_W-1:0]  priority_count
);

    ctrl_cmd_t ctrl_cmd;

    assign cfg_ready = 1'b1;

    tcpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl_cmd  (ctrl_cmd)
    );

    tcpq_datapath #(.DEPTH(QUEUE_DEPTH)) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .ctrl_cmd              (ctrl_cmd),
        .cfg_we                (cfg_valid && cfg_ready),
        .cfg_data              (cfg_data),
        .command               (command),
        .item_value            (item_value),
        .status                (status),
        .removed_value         (removed_value),
        .removed_from_priority (removed_from_priority),
        .normal_count          (normal_count),
        .priority_count        (priority_count)
    );

`ifndef SYNTHESIS
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.capture |=> in_stall)
        else $error("block took an item without entering its execute step");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |=> out_valid)
        else $error("committed item did not appear at the output");

    a_empty_has_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_BOTH_EMPTY) |-> (removed_value == '0))
        else $error("empty remove reported a value");

    a_prio_only_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && removed_from_priority) |-> (status == ST_REMOVED))
        else $error("priority source flagged on a non-remove result");
`endif

endmodule
